[rtl/core/i2c_master_transfer_sequencer_core_defines.svh]
// Assertion macros used by the checker file of the I2C transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define I2CMTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/i2cmts_pkg.sv]
// Types and constants of the I2C master transfer sequencer.
package i2cmts_pkg;

   // command codes on the mode field
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_EVENT = 2'd2;

   // finish codes
   localparam logic [1:0] FINISH_BUSY   = 2'd0;
   localparam logic [1:0] FINISH_DONE   = 2'd1;
   localparam logic [1:0] FINISH_FAILED = 2'd2;

   // bus status codes, low three bits masked off
   localparam logic [7:0] STATUS_MASK      = 8'hF8;
   localparam logic [7:0] STATUS_START     = 8'h08;
   localparam logic [7:0] STATUS_SLAW_ACK  = 8'h18;
   localparam logic [7:0] STATUS_DATA_ACK  = 8'h28;
   localparam logic [7:0] STATUS_SLAR_ACK  = 8'h40;
   localparam logic [7:0] STATUS_RX_ACK    = 8'h50;
   localparam logic [7:0] STATUS_RX_NACK   = 8'h58;

   typedef enum logic [2:0] {
      PHASE_IDLE    = 3'd0,
      PHASE_DONE    = 3'd1,
      PHASE_FAILED  = 3'd2,
      PHASE_START   = 3'd3,
      PHASE_ADDRESS = 3'd4,
      PHASE_READ    = 3'd5,
      PHASE_WRITE   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] slave_addr;
      logic [7:0] byte_count;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       send_start;
      logic       send_stop;
      logic       ack_enable;
      logic       irq_enable;
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [1:0] finish;
      logic [7:0] bytes_done;
   } rsp_payload_type;

endpackage

[rtl/core/i2cmts_channels.sv]
// Valid/ready channel interfaces for command/event items and result items.
interface i2cmts_req_if;
   logic                        valid;
   logic                        ready;
   i2cmts_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2cmts_rsp_if;
   logic                        valid;
   logic                        ready;
   i2cmts_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/i2c_master_transfer_sequencer_core.sv]
// Top level of the I2C master transfer sequencer: phase machine and result register.
//
// Usage:
//  - req_chan carries command and bus-event items. mode 0/1 starts a write/read
//    of byte_count bytes to slave_addr (bit 0 forced to the direction); mode 2
//    delivers a bus status event with the received byte and the next tx byte.
//  - rsp_chan returns exactly one result item per accepted item: START/STOP
//    requests, ACK and interrupt enables, a byte to load or a byte captured,
//    and the finish code with the byte count.
//  - Latency: the result is valid in the cycle after the item is accepted.
//  - Throughput: one item per cycle unless a result stalls. The phase update and
//    the result are one short decode from the phase register; nothing iterates.
//  - Stall: req_chan.ready = !rsp_valid_ff || rsp_chan.ready, so while a result
//    waits untaken no new item enters and the result holds its value; when the
//    receiver takes it, the next item is accepted in that same cycle.
//  - Reset (synchronous, active high): phase goes idle, the saved transfer
//    context clears and the result register empties.
//  - A start command always abandons any transfer in progress. A zero count
//    finishes at once with done. Any unexpected status reports failed.
module i2c_master_transfer_sequencer_core (
   input  logic                clock,
   input  logic                reset,
   i2cmts_req_if.sink          req_chan,
   i2cmts_rsp_if.source        rsp_chan
);

   // transfer context
   i2cmts_pkg::phase_type phase_ff, phase_in;
   logic                  is_read_ff, is_read_in;
   logic [7:0]            address_byte_ff, address_byte_in;
   logic [7:0]            remaining_ff, remaining_in;
   logic [7:0]            requested_ff, requested_in;

   // result register
   logic                        rsp_valid_ff;
   i2cmts_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic accept;

   // decode
   logic [7:0] status;
   logic       is_start_cmd;
   logic       is_event;
   logic       start_ok;    // START acknowledged, send address
   logic       rd_capture;  // a data byte arrived in read phase
   logic       to_read;
   logic       to_write;
   logic       fail;
   logic [7:0] rem_eff;     // count after this event's capture
   logic       last;        // nothing left to move

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // status decode shared by next-state and output logic
   always_comb begin
      status       = req_chan.payload.bus_status & i2cmts_pkg::STATUS_MASK;
      is_start_cmd = (req_chan.payload.mode == i2cmts_pkg::MODE_WRITE) ||
                     (req_chan.payload.mode == i2cmts_pkg::MODE_READ);
      is_event     = (req_chan.payload.mode == i2cmts_pkg::MODE_EVENT);
      start_ok     = is_event && (phase_ff == i2cmts_pkg::PHASE_START) &&
                     (status == i2cmts_pkg::STATUS_START);
      rd_capture   = is_event && (phase_ff == i2cmts_pkg::PHASE_READ) &&
                     ((status == i2cmts_pkg::STATUS_RX_ACK) ||
                      (status == i2cmts_pkg::STATUS_RX_NACK));
      to_read      = rd_capture ||
                     (is_event && (phase_ff == i2cmts_pkg::PHASE_ADDRESS) && is_read_ff &&
                      (status == i2cmts_pkg::STATUS_SLAR_ACK));
      to_write     = is_event &&
                     (((phase_ff == i2cmts_pkg::PHASE_ADDRESS) && !is_read_ff &&
                       (status == i2cmts_pkg::STATUS_SLAW_ACK)) ||
                      ((phase_ff == i2cmts_pkg::PHASE_WRITE) &&
                       (status == i2cmts_pkg::STATUS_DATA_ACK)));
      fail         = is_event && !(start_ok || to_read || to_write);
      rem_eff      = rd_capture ? (remaining_ff - 8'd1) : remaining_ff;
      last         = (rem_eff == 8'd0);
   end

   // next state
   always_comb begin
      phase_in        = phase_ff;
      is_read_in      = is_read_ff;
      address_byte_in = address_byte_ff;
      remaining_in    = remaining_ff;
      requested_in    = requested_ff;
      if (is_start_cmd) begin
         if (req_chan.payload.byte_count == 8'd0) begin
            phase_in = i2cmts_pkg::PHASE_DONE;
         end else begin
            is_read_in      = req_chan.payload.mode[0];
            address_byte_in = {req_chan.payload.slave_addr[7:1], req_chan.payload.mode[0]};
            remaining_in    = req_chan.payload.byte_count;
            requested_in    = req_chan.payload.byte_count;
            phase_in        = i2cmts_pkg::PHASE_START;
         end
      end else if (start_ok) begin
         phase_in = i2cmts_pkg::PHASE_ADDRESS;
      end else if (to_read) begin
         remaining_in = rem_eff;
         if (last) begin
            phase_in = i2cmts_pkg::PHASE_DONE;
         end else begin
            phase_in = i2cmts_pkg::PHASE_READ;
         end
      end else if (to_write) begin
         if (last) begin
            phase_in = i2cmts_pkg::PHASE_DONE;
         end else begin
            remaining_in = remaining_ff - 8'd1;
            phase_in     = i2cmts_pkg::PHASE_WRITE;
         end
      end else if (fail) begin
         phase_in = i2cmts_pkg::PHASE_FAILED;
      end
   end

   // result item
   always_comb begin
      rsp_payload_in = '0;
      if (is_start_cmd) begin
         if (req_chan.payload.byte_count == 8'd0) begin
            rsp_payload_in.finish = i2cmts_pkg::FINISH_DONE;
         end else begin
            rsp_payload_in.send_start = 1'b1;
            rsp_payload_in.irq_enable = 1'b1;
         end
      end else if (start_ok) begin
         rsp_payload_in.tx_valid   = 1'b1;
         rsp_payload_in.tx_data    = address_byte_ff;
         rsp_payload_in.irq_enable = 1'b1;
      end else if (to_read || to_write) begin
         if (rd_capture) begin
            rsp_payload_in.rx_valid = 1'b1;
            rsp_payload_in.rx_data  = req_chan.payload.rx_byte;
         end
         if (last) begin
            rsp_payload_in.send_stop  = 1'b1;
            rsp_payload_in.finish     = i2cmts_pkg::FINISH_DONE;
            rsp_payload_in.bytes_done = requested_ff;
         end else if (to_read) begin
            // NACK the final byte
            rsp_payload_in.ack_enable = (rem_eff != 8'd1);
            rsp_payload_in.irq_enable = 1'b1;
         end else begin
            rsp_payload_in.tx_valid   = 1'b1;
            rsp_payload_in.tx_data    = req_chan.payload.tx_byte;
            rsp_payload_in.irq_enable = 1'b1;
         end
      end else if (fail) begin
         rsp_payload_in.finish = i2cmts_pkg::FINISH_FAILED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= i2cmts_pkg::PHASE_IDLE;
         is_read_ff      <= 1'b0;
         address_byte_ff <= 8'd0;
         remaining_ff    <= 8'd0;
         requested_ff    <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            is_read_ff      <= is_read_in;
            address_byte_ff <= address_byte_in;
            remaining_ff    <= remaining_in;
            requested_ff    <= requested_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

[rtl/core/i2cmts_checker.sv]
// Port-level assertions for the I2C transfer sequencer, bound to its top level.
`include "i2c_master_transfer_sequencer_core_defines.svh"

module i2cmts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input i2cmts_pkg::req_payload_type req_payload,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input i2cmts_pkg::rsp_payload_type rsp_payload
);

   logic req_accept;
   logic start_cmd;

   assign req_accept = req_valid && req_ready;
   assign start_cmd  = ((req_payload.mode == i2cmts_pkg::MODE_WRITE) ||
                        (req_payload.mode == i2cmts_pkg::MODE_READ)) &&
                       (req_payload.byte_count != 8'd0);

   `I2CMTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

   `I2CMTS_ASSERT_NEXT(a_one_cycle, req_accept, rsp_valid, "no result one cycle after an accepted item")

   `I2CMTS_ASSERT_NEXT(a_start_req, req_accept && start_cmd, rsp_payload.send_start && rsp_payload.irq_enable && (rsp_payload.finish == i2cmts_pkg::FINISH_BUSY), "start command did not request START")

   `I2CMTS_ASSERT_SAME(a_fail_quiet, rsp_valid && (rsp_payload.finish == i2cmts_pkg::FINISH_FAILED), !rsp_payload.send_stop && !rsp_payload.irq_enable && !rsp_payload.tx_valid && (rsp_payload.bytes_done == 8'd0), "failure result requests bus activity")

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
